// ===== src/apsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsv_pkg
// Types, request codes and the volume code mapping for the amplifier
// power-up sequencer.
// ----------------------------------------------------------------------------
package apsv_pkg;

    // request codes on the input beat
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_DONE = 2'd1;
    localparam logic [1:0] REQ_VOL  = 2'd2;
    localparam logic [1:0] REQ_MUTE = 2'd3;

    // default delays in milliseconds
    localparam int unsigned BOOT_DELAY_MS      = 10;
    localparam int unsigned POWERDOWN_DELAY_MS = 20;
    localparam int unsigned RESET_DELAY_MS     = 20;
    localparam int unsigned PVDD_DELAY_MS      = 5;
    localparam int unsigned TRIM_DELAY_MS      = 50;
    localparam int unsigned PWM_RATE_DELAY_MS  = 250;

    localparam logic [7:0] VOL_REG_ADDR    = 8'h07;
    localparam logic [9:0] VOL_CODE_TOP    = 10'h3FE;
    localparam logic [9:0] VOL_CODE_SILENT = 10'h3FF;
    localparam logic [9:0] VOL_CODE_0DB    = 10'h0C0;
    localparam logic [7:0] VOL_MAX         = 8'd100;
    localparam int unsigned VOL_DIV        = 99;

    // division by 99 as multiply by reciprocal, exact for the whole range
    localparam int unsigned VOL_SPAN        = 830;
    localparam int unsigned VOL_RECIP_SHIFT = 23;
    localparam int unsigned VOL_RECIP       = ((2 ** VOL_RECIP_SHIFT) + VOL_DIV - 1) / VOL_DIV;
    localparam int unsigned VOL_SCALE       = VOL_SPAN * VOL_RECIP;
    localparam int unsigned VOL_BIAS        = ((VOL_DIV - 1) / 2) * VOL_RECIP;

    typedef struct packed {
        logic [1:0] req_type;
        logic       write_ok;
        logic [7:0] volume_level;
        logic       mute_request;
    } t_in;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic       powerdown_released;
        logic       reset_released;
        logic       pvdd_enable;
        logic       ready_res;
        logic [6:0] volume_now;
        logic       muted_now;
        logic [4:0] state_code;
    } t_out;

    // status snapshot held with a burst
    typedef struct packed {
        logic [2:0] pins;
        logic       ready;
        logic [6:0] vol;
        logic       mute;
        logic [4:0] state;
    } t_status;

    // one register write: byte count and bytes, element 0 sent first
    typedef struct packed {
        logic [2:0]      len;
        logic [4:0][7:0] bytes;
    } t_wr;

    function automatic logic [9:0] vol_code(logic [6:0] vol, logic mute);
        logic [32:0] prod;
        logic [9:0]  off;
        logic [9:0]  code;
        prod = 33'(7'(vol - 7'd1)) * 33'(VOL_SCALE) + 33'(VOL_BIAS);
        off  = 10'(prod >> VOL_RECIP_SHIFT);
        if (mute || vol == 7'd0) begin
            code = VOL_CODE_SILENT;
        end else begin
            code = VOL_CODE_TOP - off;
        end
        return code;
    endfunction

endpackage

// ===== src/amp_powerup_sequencer_volume.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amp_powerup_sequencer_volume
// Power-up sequencer for an audio amplifier: delays, pin releases, a fixed
// list of register writes, then upkeep of the volume register.
// ----------------------------------------------------------------------------
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+----------------------------
//  input    | i_in_valid   | o_in_ready   | i_in_data  (apsv_pkg::t_in)
//  output   | o_out_valid  | i_out_ready  | o_out_data (apsv_pkg::t_out)
//
// an input beat is handled in the cycle it is accepted and its results
// (one to five beats, set by the number of write bytes it produces) are
// loaded into the output buffer, which then sends one beat a cycle while
// the output is ready.
// a new input is taken in the cycle the last beat of the previous burst
// leaves, so bursts follow each other with no gap.
// reset is synchronous; no clearing pass is needed.
// output stalls hold the buffer and block further inputs.
// ----------------------------------------------------------------------------
module amp_powerup_sequencer_volume #(
    parameter int unsigned BOOT_DELAY_MS      = apsv_pkg::BOOT_DELAY_MS,
    parameter int unsigned POWERDOWN_DELAY_MS = apsv_pkg::POWERDOWN_DELAY_MS,
    parameter int unsigned RESET_DELAY_MS     = apsv_pkg::RESET_DELAY_MS,
    parameter int unsigned PVDD_DELAY_MS      = apsv_pkg::PVDD_DELAY_MS,
    parameter int unsigned TRIM_DELAY_MS      = apsv_pkg::TRIM_DELAY_MS,
    parameter int unsigned PWM_RATE_DELAY_MS  = apsv_pkg::PWM_RATE_DELAY_MS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  apsv_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output apsv_pkg::t_out o_out_data
);

    typedef enum logic [4:0] {
        ST_INIT     = 5'd0,
        ST_PD_REL   = 5'd1,
        ST_RST_REL  = 5'd2,
        ST_PVDD     = 5'd3,
        ST_TRIM     = 5'd4,
        ST_TRIM_DLY = 5'd5,
        ST_I2S      = 5'd6,
        ST_BD1      = 5'd7,
        ST_BD2      = 5'd8,
        ST_BD3      = 5'd9,
        ST_BD4      = 5'd10,
        ST_INMUX    = 5'd11,
        ST_PWM      = 5'd12,
        ST_PWM_DLY  = 5'd13,
        ST_EXIT_SD  = 5'd14,
        ST_RUNNING  = 5'd15,
        ST_VOLUME   = 5'd16
    } t_state;

    // fixed register writes issued on entry to each write state
    function automatic apsv_pkg::t_wr rom_write(t_state s);
        apsv_pkg::t_wr w;
        w = '0;
        case (s)
            ST_TRIM:    begin w.len = 3'd2; w.bytes = {24'h0, 8'h00, 8'h1b}; end
            ST_I2S:     begin w.len = 3'd2; w.bytes = {24'h0, 8'h03, 8'h04}; end
            ST_BD1:     begin w.len = 3'd2; w.bytes = {24'h0, 8'hb8, 8'h11}; end
            ST_BD2:     begin w.len = 3'd2; w.bytes = {24'h0, 8'h60, 8'h12}; end
            ST_BD3:     begin w.len = 3'd2; w.bytes = {24'h0, 8'ha0, 8'h13}; end
            ST_BD4:     begin w.len = 3'd2; w.bytes = {24'h0, 8'h48, 8'h14}; end
            ST_INMUX:   begin
                w.len   = 3'd5;
                w.bytes = {8'h72, 8'h77, 8'h89, 8'h00, 8'h20};
            end
            ST_PWM:     begin
                w.len   = 3'd5;
                w.bytes = {8'h08, 8'h00, 8'h00, 8'h00, 8'h4f};
            end
            ST_EXIT_SD: begin w.len = 3'd2; w.bytes = {24'h0, 8'h00, 8'h05}; end
            default:    w = '0;
        endcase
        return w;
    endfunction

    // state entered once the write of state s completes
    function automatic t_state after_write(t_state s);
        t_state a;
        case (s)
            ST_TRIM:    a = ST_TRIM_DLY;
            ST_I2S:     a = ST_BD1;
            ST_BD1:     a = ST_BD2;
            ST_BD2:     a = ST_BD3;
            ST_BD3:     a = ST_BD4;
            ST_BD4:     a = ST_INMUX;
            ST_INMUX:   a = ST_PWM;
            ST_PWM:     a = ST_PWM_DLY;
            ST_EXIT_SD: a = ST_RUNNING;
            ST_VOLUME:  a = ST_RUNNING;
            default:    a = ST_INIT;
        endcase
        return a;
    endfunction

    // sequencer state
    t_state     r_state,   n_state;
    logic [7:0] r_wait,    n_wait;
    logic [6:0] r_vol,     n_vol;
    logic       r_mute,    n_mute;
    logic [9:0] r_written, n_written;
    logic [9:0] r_target,  n_target;
    logic [2:0] r_pins,    n_pins;
    logic       r_ready,   n_ready;

    // output buffer
    logic              r_busy;
    logic [2:0]        r_idx;
    logic [2:0]        r_last_idx;
    logic              r_tx;
    logic [4:0][7:0]   r_bytes;
    apsv_pkg::t_status r_stat;

    logic          in_fire;
    logic          out_fire;
    logic          out_last;
    logic          enter_en;
    t_state        enter_s;
    apsv_pkg::t_wr wr;
    apsv_pkg::t_wr cur_wr;
    logic          is_delay;
    logic          is_write;
    logic [6:0]    vol_sat;

    assign out_last    = (r_idx == r_last_idx);
    assign out_fire    = r_busy && i_out_ready;
    assign o_in_ready  = !r_busy || (out_fire && out_last);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_busy;

    always_comb begin
        o_out_data                    = '0;
        o_out_data.tx_valid           = r_tx;
        o_out_data.tx_byte            = r_bytes[r_idx];
        o_out_data.last               = out_last;
        o_out_data.powerdown_released = r_stat.pins[0];
        o_out_data.reset_released     = r_stat.pins[1];
        o_out_data.pvdd_enable        = r_stat.pins[2];
        o_out_data.ready_res          = r_stat.ready;
        o_out_data.volume_now         = r_stat.vol;
        o_out_data.muted_now          = r_stat.mute;
        o_out_data.state_code         = r_stat.state;
    end

    assign cur_wr   = rom_write(r_state);
    assign is_delay = (r_state == ST_INIT) || (r_state == ST_PD_REL) ||
                      (r_state == ST_RST_REL) || (r_state == ST_PVDD) ||
                      (r_state == ST_TRIM_DLY) || (r_state == ST_PWM_DLY);
    assign is_write = (r_state == ST_VOLUME) || (cur_wr.len != 3'd0);
    assign vol_sat  = (i_in_data.volume_level > apsv_pkg::VOL_MAX) ?
                      7'(apsv_pkg::VOL_MAX) : i_in_data.volume_level[6:0];

    always_comb begin
        n_state   = r_state;
        n_wait    = r_wait;
        n_vol     = r_vol;
        n_mute    = r_mute;
        n_written = r_written;
        n_target  = r_target;
        n_pins    = r_pins;
        n_ready   = r_ready;
        enter_en  = 1'b0;
        enter_s   = r_state;
        wr        = '0;

        unique case (i_in_data.req_type)
            apsv_pkg::REQ_TICK: begin
                if (is_delay) begin
                    if (r_wait <= 8'd1) begin
                        n_wait   = 8'd0;
                        enter_en = 1'b1;
                        enter_s  = (r_state == ST_PWM_DLY) ? ST_EXIT_SD :
                                   t_state'(5'(r_state + 5'd1));
                    end else begin
                        n_wait = r_wait - 8'd1;
                    end
                end
            end
            apsv_pkg::REQ_DONE: begin
                if (i_in_data.write_ok && is_write) begin
                    enter_en = 1'b1;
                    // target moved while the volume write was in flight
                    if (r_state == ST_VOLUME && r_written != r_target) begin
                        enter_s = ST_VOLUME;
                    end else begin
                        if (r_state == ST_EXIT_SD) begin
                            n_ready = 1'b1;
                        end
                        enter_s = after_write(r_state);
                    end
                end
            end
            apsv_pkg::REQ_VOL: begin
                n_vol    = vol_sat;
                n_target = apsv_pkg::vol_code(vol_sat, r_mute);
                if (n_target != r_target && r_state == ST_RUNNING) begin
                    enter_en = 1'b1;
                    enter_s  = ST_VOLUME;
                end
            end
            apsv_pkg::REQ_MUTE: begin
                if (i_in_data.mute_request != r_mute) begin
                    n_mute   = i_in_data.mute_request;
                    n_target = apsv_pkg::vol_code(r_vol, i_in_data.mute_request);
                    if (n_target != r_target && r_state == ST_RUNNING) begin
                        enter_en = 1'b1;
                        enter_s  = ST_VOLUME;
                    end
                end
            end
        endcase

        if (enter_en) begin
            n_state = enter_s;
            case (enter_s)
                ST_PD_REL: begin
                    n_pins = r_pins | 3'b001;
                    n_wait = 8'(POWERDOWN_DELAY_MS);
                end
                ST_RST_REL: begin
                    n_pins = r_pins | 3'b010;
                    n_wait = 8'(RESET_DELAY_MS);
                end
                ST_PVDD: begin
                    n_pins = r_pins | 3'b100;
                    n_wait = 8'(PVDD_DELAY_MS);
                end
                ST_TRIM_DLY: n_wait = 8'(TRIM_DELAY_MS);
                ST_PWM_DLY:  n_wait = 8'(PWM_RATE_DELAY_MS);
                ST_VOLUME: begin
                    n_written = n_target;
                    wr.len    = 3'd3;
                    wr.bytes  = {16'h0, n_target[7:0], {6'b0, n_target[9:8]},
                                 apsv_pkg::VOL_REG_ADDR};
                end
                default: wr = rom_write(enter_s);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_wait     <= 8'(BOOT_DELAY_MS);
            r_vol      <= 7'd1;
            r_mute     <= 1'b1;
            r_written  <= 10'd0;
            r_target   <= apsv_pkg::VOL_CODE_SILENT;
            r_pins     <= 3'b000;
            r_ready    <= 1'b0;
            r_busy     <= 1'b0;
            r_idx      <= 3'd0;
            r_last_idx <= 3'd0;
        end else begin
            if (in_fire) begin
                r_state    <= n_state;
                r_wait     <= n_wait;
                r_vol      <= n_vol;
                r_mute     <= n_mute;
                r_written  <= n_written;
                r_target   <= n_target;
                r_pins     <= n_pins;
                r_ready    <= n_ready;
                r_busy     <= 1'b1;
                r_idx      <= 3'd0;
                r_last_idx <= (wr.len == 3'd0) ? 3'd0 : wr.len - 3'd1;
                // burst payload, no reset needed
                r_tx         <= (wr.len != 3'd0);
                r_bytes      <= wr.bytes;
                r_stat.pins  <= n_pins;
                r_stat.ready <= n_ready;
                r_stat.vol   <= n_vol;
                r_stat.mute  <= n_mute;
                r_stat.state <= n_state;
            end else if (out_fire) begin
                if (out_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    // a burst is never cut short
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |=> o_out_valid)
        else $error("burst ended before its last beat");

    // running or volume upkeep only after the exit-shutdown write completed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUNNING || r_state == ST_VOLUME) |-> r_ready)
        else $error("running without ready");

    // supply comes up only after powerdown and reset are released
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pins[2] |-> (r_pins[1] && r_pins[0]))
        else $error("pvdd enabled out of order");

    // ready stays set once set
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |=> r_ready)
        else $error("ready flag dropped");

endmodule
